// ===== rtl/core/rie_pkg.sv =====
// package for the register instruction executor: sizes, opcodes, status codes, stage types
package rie_pkg;
  localparam int NUM_REGS = 256;
  localparam int NUM_LABELS = 256;
  localparam int STACK_DEPTH = 64;
  localparam int NUM_GLOBALS = 256;
  localparam int IP_WIDTH = 16;
  localparam int REG_AW = $clog2(NUM_REGS);
  localparam int LBL_AW = $clog2(NUM_LABELS);
  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int GLB_AW = $clog2(NUM_GLOBALS);
  localparam int CLR_W = (REG_AW > LBL_AW) ? ((REG_AW > GLB_AW) ? REG_AW : GLB_AW)
                                           : ((LBL_AW > GLB_AW) ? LBL_AW : GLB_AW);

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_MOVE = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
    OP_DIV = 5'd5, OP_MOD = 5'd6, OP_EQ = 5'd7, OP_GT = 5'd8, OP_LT = 5'd9,
    OP_GE = 5'd10, OP_LE = 5'd11, OP_AND = 5'd12, OP_OR = 5'd13, OP_XOR = 5'd14,
    OP_SHL = 5'd15, OP_SHR = 5'd16, OP_JUMP = 5'd17, OP_JIF = 5'd18,
    OP_JIFN = 5'd19, OP_CALL = 5'd20, OP_RET = 5'd21, OP_LDG = 5'd22,
    OP_STG = 5'd23, OP_HALT = 5'd24, OP_DEFL = 5'd25
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_HALT = 3'd1, ST_DIVZ = 3'd2, ST_OVF = 3'd3, ST_BADOP = 3'd4,
    ST_BADJMP = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_WRITE
  } state_e;

  typedef enum logic [1:0] {
    K_REG = 2'd0, K_IMM = 2'd1, K_OTHER = 2'd2
  } kind_e;

  typedef struct packed {
    logic [4:0]  func;
    logic        dest_is_reg;
    logic [7:0]  dest_reg;
    logic [1:0]  src1_kind;
    logic [7:0]  src1_reg;
    logic [63:0] src1_imm;
    logic [1:0]  src2_kind;
    logic [7:0]  src2_reg;
    logic [63:0] src2_imm;
    logic        target_is_label;
    logic [7:0]  target_label;
    logic [15:0] label_position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_ip;
    logic        reg_written;
    logic [7:0]  written_reg;
    logic [63:0] written_value;
  } out_t;

  typedef struct packed {
    logic        start;
    logic        sign_q;
    logic        sign_r;
    logic [63:0] a;
    logic [63:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
    logic [63:0] r;
  } div_rsp_t;
endpackage

// ===== rtl/core/rie_if.sv =====
// valid/ready channel interface with a generic payload
interface rie_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/register_ir_instruction_executor_core.sv =====
// top level: instruction sequencer around register, label, stack and global memories
// in_i carries one instruction (rie_pkg::in_t) per transfer and out_o returns one
// result (rie_pkg::out_t) per instruction. An instruction walks accept, register read,
// execute and write-back; its result is registered at write-back, and the next
// instruction can be taken in the cycle after write-back.
// Multiply passes through an extra S_MUL state to sum its three 32x32 partial products.
// Divide and modulo wait in S_DIV for the bit-serial divider;
// a zero divisor skips the divider and goes straight to write-back.
// Load_global reads the global memory in the execute cycle, indexed by the src1 value.
// One output register parts the two sides: while the receiver stalls, the block takes
// the next instruction and runs it up to write-back, then holds there with in_i.ready
// low until the waiting result is transferred.
// After reset a clearing pass zeroes the register, label and global
// memories, one entry of each per cycle; in_i.ready stays low meanwhile.
// The return stack is not cleared; only pushed entries are ever popped.
module register_ir_instruction_executor_core (
  input  logic clk_i,
  input  logic rst_ni,
  rie_if.sink   in_i,
  rie_if.source out_o
);
  import rie_pkg::*;

  state_e state_q, state_d;
  logic [CLR_W:0] clr_q;

  logic [4:0]  func_q;
  logic        dir_q, til_q;
  logic [7:0]  dreg_q, lbl_q;
  logic [1:0]  k1_q, k2_q;
  logic [7:0]  r1_q, r2_q;
  logic [63:0] i1_q, i2_q;
  logic [15:0] pos_q;

  logic [63:0] rf [NUM_REGS];
  logic [IP_WIDTH-1:0] lt [NUM_LABELS];
  logic [IP_WIDTH-1:0] rs [STACK_DEPTH];
  logic [63:0] gs [NUM_GLOBALS];
  logic [63:0] rd1_q, rd2_q, gd_q;
  logic [IP_WIDTH-1:0] ld_q, sd_q;

  logic [IP_WIDTH-1:0] ip_q;
  logic [DEPTH_W-1:0] dep_q;

  logic [63:0] a, b;
  logic [63:0] pll_q;
  logic [31:0] plh_q, phl_q;
  logic [63:0] prod_q;
  div_req_t dreq;
  div_rsp_t drsp;

  logic        ov_q;
  logic [2:0]  ost_q;
  logic [15:0] oip_q;
  logic        ow_q;
  logic [7:0]  oreg_q;
  logic [63:0] oval_q;

  rie_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  wire accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  wire clearing = (state_q == S_CLEAR);
  wire do_wr = (state_q == S_WRITE) && (!ov_q || out_o.ready);

  // source reads: register memory read in S_READ, valid in S_EXEC
  always_comb begin
    unique case (k1_q)
      K_REG:   a = (32'(r1_q) < NUM_REGS) ? rd1_q : 64'd0;
      K_IMM:   a = i1_q;
      default: a = 64'd0;
    endcase
    unique case (k2_q)
      K_REG:   b = (32'(r2_q) < NUM_REGS) ? rd2_q : 64'd0;
      K_IMM:   b = i2_q;
      default: b = 64'd0;
    endcase
  end

  // memory reads; global address is src1 value, known only in S_EXEC, so
  // load_global reads gs in S_EXEC and the result is used in S_WRITE
  always_ff @(posedge clk_i) begin
    rd1_q <= rf[r1_q[REG_AW-1:0]];
    rd2_q <= rf[r2_q[REG_AW-1:0]];
    ld_q  <= lt[lbl_q[LBL_AW-1:0]];
    sd_q  <= rs[STK_AW'(dep_q - DEPTH_W'(1))];
    gd_q  <= gs[a[GLB_AW-1:0]];
  end

  // low 64 bits of the product from three 32x32 partial products
  always_ff @(posedge clk_i) begin
    pll_q  <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
    plh_q  <= a[31:0] * b[63:32];
    phl_q  <= a[63:32] * b[31:0];
    prod_q <= pll_q + {plh_q + phl_q, 32'd0};
  end

  // execution result, evaluated in S_WRITE from registered operands
  logic [2:0]  st;
  logic        wr, adv, setip, rf0;
  logic [63:0] wv;
  logic [IP_WIDTH-1:0] nip;
  logic        lok, slt_ab, slt_ba, push, pop, glw, lbw;

  always_comb begin
    lok = til_q && (32'(lbl_q) < NUM_LABELS);
    slt_ab = $signed(a) < $signed(b);
    slt_ba = $signed(b) < $signed(a);
    st = ST_OK; wr = 1'b0; wv = 64'd0; adv = 1'b1; setip = 1'b0; nip = ld_q;
    rf0 = 1'b0; push = 1'b0; pop = 1'b0; glw = 1'b0; lbw = 1'b0;
    unique case (func_q)
      OP_NOP: ;
      OP_MOVE: begin wr = 1'b1; wv = a; end
      OP_ADD: begin wr = 1'b1; wv = a + b; end
      OP_SUB: begin wr = 1'b1; wv = a - b; end
      OP_MUL: begin wr = 1'b1; wv = prod_q; end
      OP_DIV, OP_MOD: begin
        if (b == 64'd0) begin st = ST_DIVZ; adv = 1'b0; end
        else begin wr = 1'b1; wv = (func_q == OP_DIV) ? drsp.q : drsp.r; end
      end
      OP_EQ: begin wr = 1'b1; wv = {63'd0, a == b}; end
      OP_GT: begin wr = 1'b1; wv = {63'd0, slt_ba}; end
      OP_LT: begin wr = 1'b1; wv = {63'd0, slt_ab}; end
      OP_GE: begin wr = 1'b1; wv = {63'd0, !slt_ab}; end
      OP_LE: begin wr = 1'b1; wv = {63'd0, !slt_ba}; end
      OP_AND: begin wr = 1'b1; wv = a & b; end
      OP_OR: begin wr = 1'b1; wv = a | b; end
      OP_XOR: begin wr = 1'b1; wv = a ^ b; end
      OP_SHL: begin wr = 1'b1; wv = a << b[5:0]; end
      OP_SHR: begin wr = 1'b1; wv = $unsigned($signed(a) >>> b[5:0]); end
      OP_JUMP: begin
        adv = 1'b0;
        if (lok) setip = 1'b1; else st = ST_BADJMP;
      end
      OP_JIF, OP_JIFN: begin
        if (((func_q == OP_JIF) ? (a != 64'd0) : (a == 64'd0)) && til_q) begin
          adv = 1'b0;
          if (lok) setip = 1'b1; else st = ST_BADJMP;
        end
      end
      OP_CALL: begin
        adv = 1'b0;
        if (32'(dep_q) >= STACK_DEPTH) st = ST_OVF;
        else begin
          push = 1'b1;
          if (lok) setip = 1'b1; else st = ST_BADJMP;
        end
      end
      OP_RET: begin
        adv = 1'b0; rf0 = 1'b1; wv = a;
        if (dep_q != '0) begin pop = 1'b1; setip = 1'b1; nip = sd_q; end
        else st = ST_HALT;
      end
      OP_LDG: begin
        wr = 1'b1; wv = (a < 64'(NUM_GLOBALS)) ? gd_q : 64'd0;
      end
      OP_STG: glw = (a < 64'(NUM_GLOBALS));
      OP_HALT: begin st = ST_HALT; adv = 1'b0; end
      OP_DEFL: begin adv = 1'b0; lbw = (32'(lbl_q) < NUM_LABELS); end
      default: begin st = ST_BADOP; adv = 1'b0; end
    endcase
    if (!(wr && dir_q && (32'(dreg_q) < NUM_REGS))) begin
      wr = 1'b0;
      if (!rf0) wv = 64'd0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q[CLR_W]) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC: begin
        priority if (func_q == OP_MUL) state_d = S_MUL;
        else if ((func_q == OP_DIV || func_q == OP_MOD) && b != 64'd0) state_d = S_DIV;
        else state_d = S_WRITE;
      end
      S_MUL:   state_d = S_WRITE;
      S_DIV:   if (drsp.done) state_d = S_WRITE;
      S_WRITE: if (do_wr) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // divider request
  always_comb begin
    dreq.start  = (state_q == S_EXEC) && (state_d == S_DIV);
    dreq.sign_q = a[63] ^ b[63];
    dreq.sign_r = a[63];
    dreq.a      = a[63] ? (64'd0 - a) : a;
    dreq.b      = b[63] ? (64'd0 - b) : b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; ip_q <= '0; dep_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (do_wr) begin
        if (setip) ip_q <= nip;
        else if (adv) ip_q <= ip_q + 1'b1;
        if (push) dep_q <= dep_q + 1'b1;
        if (pop) dep_q <= dep_q - 1'b1;
        ov_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // write ports; clearing pass shares them
  always_ff @(posedge clk_i) begin
    if (clearing && !clr_q[CLR_W]) begin
      rf[clr_q[REG_AW-1:0]] <= 64'd0;
      lt[clr_q[LBL_AW-1:0]] <= '0;
      gs[clr_q[GLB_AW-1:0]] <= 64'd0;
    end else if (do_wr) begin
      if (rf0) rf[0] <= wv;
      else if (wr) rf[dreg_q[REG_AW-1:0]] <= wv;
      if (lbw) lt[lbl_q[LBL_AW-1:0]] <= pos_q[IP_WIDTH-1:0];
      if (glw) gs[a[GLB_AW-1:0]] <= b;
    end
    if (do_wr && push) rs[dep_q[STK_AW-1:0]] <= ip_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.data.func; dir_q <= in_i.data.dest_is_reg;
      dreg_q <= in_i.data.dest_reg; k1_q <= in_i.data.src1_kind;
      r1_q <= in_i.data.src1_reg; i1_q <= in_i.data.src1_imm;
      k2_q <= in_i.data.src2_kind; r2_q <= in_i.data.src2_reg;
      i2_q <= in_i.data.src2_imm; til_q <= in_i.data.target_is_label;
      lbl_q <= in_i.data.target_label; pos_q <= in_i.data.label_position;
    end
    if (do_wr) begin
      ost_q <= st;
      oip_q <= 16'(setip ? nip : (adv ? ip_q + 1'b1 : ip_q));
      ow_q <= wr || rf0;
      oreg_q <= (wr && !rf0) ? dreg_q : 8'd0;
      oval_q <= wv;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data.status = ost_q;
  assign out_o.data.next_ip = oip_q;
  assign out_o.data.reg_written = ow_q;
  assign out_o.data.written_reg = oreg_q;
  assign out_o.data.written_value = oval_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr |-> !ov_q || (out_o.valid && out_o.ready)) else $error("result overrun");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(dep_q) <= STACK_DEPTH) else $error("stack depth out of range");
endmodule

// ===== rtl/core/rie_divider.sv =====
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
module rie_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rie_pkg::div_req_t req_i,
  output rie_pkg::div_rsp_t rsp_o
);
  import rie_pkg::*;
  logic [63:0] n_q, n_d, d_q, d_d, q_q, q_d;
  logic [64:0] r_q, r_d, trial;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, sq_q, sq_d, sr_q, sr_d;

  always_comb begin
    n_d = n_q; d_d = d_q; q_d = q_q; r_d = r_q; cnt_d = cnt_q;
    busy_d = busy_q; sq_d = sq_q; sr_d = sr_q;
    trial = {r_q[63:0], n_q[63]} - {1'b0, d_q};
    if (req_i.start) begin
      n_d = req_i.a; d_d = req_i.b; q_d = '0; r_d = '0; cnt_d = 7'd64;
      busy_d = 1'b1; sq_d = req_i.sign_q; sr_d = req_i.sign_r;
    end else if (busy_q) begin
      if (!trial[64]) begin
        r_d = trial; q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = {r_q[63:0], n_q[63]}; q_d = {q_q[62:0], 1'b0};
      end
      n_d = {n_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; q_q <= q_d; r_q <= r_d; sq_q <= sq_d; sr_q <= sr_d;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= busy_q && (cnt_q == 7'd1);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q = sq_q ? (64'd0 - q_q) : q_q;
  assign rsp_o.r = sr_q ? (64'd0 - r_q[63:0]) : r_q[63:0];
endmodule
